// ===== rtl/height_map_box_smooth_core_macros.svh =====
// assertion macros for the height map box smooth core
`ifndef HEIGHT_MAP_BOX_SMOOTH_CORE_MACROS_SVH
`define HEIGHT_MAP_BOX_SMOOTH_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HMBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define HMBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hmbs_pkg.sv =====
// shared types and constants of the height map box smooth core
`default_nettype none
package hmbs_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int INDEX_BITS   = 10;
  localparam int CFG_BITS     = 11;
  localparam int ROW_BITS     = 11;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int WIN_TAPS     = 9;
  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 3;

  localparam logic [CFG_BITS-1:0] MAP_WIDTH_RESET  = 11'd256;
  localparam logic [CFG_BITS-1:0] MAP_HEIGHT_RESET = 11'd256;

  typedef enum logic {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [WIN_TAPS-1:0] window_t;

  typedef struct packed {
    sample_t height_sample;
    logic    flush;
  } sample_req_t;

  typedef struct packed {
    sample_t                smoothed_height;
    logic [INDEX_BITS-1:0]  row_index;
    logic [INDEX_BITS-1:0]  col_index;
    logic                   frame_last;
  } smooth_req_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] row_index;
    logic [INDEX_BITS-1:0] col_index;
    logic                  frame_last;
    logic                  row_up;
    logic                  row_dn;
    logic                  col_left;
    logic                  col_right;
  } point_tag_t;

endpackage
`default_nettype wire

// ===== rtl/hmbs_mean.sv =====
// masked 3x3 window sum and rounded division by the neighbour count
`default_nettype none
module hmbs_mean (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 win_valid,
  output logic                      win_ready,
  input  wire hmbs_pkg::window_t    win,
  input  wire hmbs_pkg::point_tag_t tag,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output hmbs_pkg::smooth_req_t     res
);
  import hmbs_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + 4;
  localparam int XB = SUM_BITS;
  localparam logic [XB-1:0] RECIP_3 = XB'((64'd1 << XB) / 3);
  localparam logic [XB-1:0] RECIP_9 = XB'((64'd1 << XB) / 9);

  typedef enum logic [1:0] {
    DIV_1 = 2'd0,
    DIV_3 = 2'd1,
    DIV_9 = 2'd2
  } divisor_t;

  logic a_valid, b_valid, c_valid, d_valid;
  logic a_ready, b_ready, c_ready, d_ready;

  logic [2:0] col_ok, row_ok;
  logic [1:0] ncol, nrow;
  logic signed [SUM_BITS-1:0] sum_next;
  logic [3:0] n_next;

  logic signed [SUM_BITS-1:0] a_sum;
  logic [3:0] a_n;
  point_tag_t a_tag;

  logic [SUM_BITS-1:0] b_abs;
  logic [XB-1:0] b_x;
  logic [1:0] b_shift;
  divisor_t b_div_next;
  logic [XB-1:0] b_xs;
  divisor_t b_div;
  logic b_neg;
  point_tag_t b_tag;

  logic [XB-1:0] recip;
  logic [2*XB-1:0] c_prod;
  logic [XB-1:0] c_xs;
  divisor_t c_div;
  logic c_neg;
  point_tag_t c_tag;

  logic [XB-1:0] q0, qm, m, rem, q, qs;

  assign d_ready = !d_valid || res_ready;
  assign c_ready = !c_valid || d_ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign win_ready = a_ready;
  assign res_valid = d_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= win_valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
    end
  end

  // window sum over in-bounds taps
  always_comb begin
    col_ok = {tag.col_right, 1'b1, tag.col_left};
    row_ok = {tag.row_dn, 1'b1, tag.row_up};
    ncol = 2'd1 + 2'(tag.col_left) + 2'(tag.col_right);
    nrow = 2'd1 + 2'(tag.row_up) + 2'(tag.row_dn);
    n_next = 4'(ncol) * 4'(nrow);
    sum_next = '0;
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        if (col_ok[k] && row_ok[r]) begin
          sum_next = sum_next + SUM_BITS'(win[k*3+r]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && win_valid) begin
      a_sum <= sum_next;
      a_n   <= n_next;
      a_tag <= tag;
    end
  end

  // (2|s| + n) / 2n split into a shift and a divide by 1, 3 or 9
  always_comb begin
    b_abs = a_sum[SUM_BITS-1] ? -a_sum : a_sum;
    b_x = {b_abs[SUM_BITS-2:0], 1'b0} + XB'(a_n);
    case (a_n)
      4'd1: begin b_shift = 2'd1; b_div_next = DIV_1; end
      4'd2: begin b_shift = 2'd2; b_div_next = DIV_1; end
      4'd3: begin b_shift = 2'd1; b_div_next = DIV_3; end
      4'd4: begin b_shift = 2'd3; b_div_next = DIV_1; end
      4'd6: begin b_shift = 2'd2; b_div_next = DIV_3; end
      4'd9: begin b_shift = 2'd1; b_div_next = DIV_9; end
      default: begin b_shift = 2'd1; b_div_next = DIV_1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_xs  <= b_x >> b_shift;
      b_div <= b_div_next;
      b_neg <= a_sum[SUM_BITS-1];
      b_tag <= a_tag;
    end
  end

  assign recip = (b_div == DIV_9) ? RECIP_9 : RECIP_3;

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_prod <= (2*XB)'(b_xs) * (2*XB)'(recip);
      c_xs   <= b_xs;
      c_div  <= b_div;
      c_neg  <= b_neg;
      c_tag  <= b_tag;
    end
  end

  // reciprocal estimate is at most one low
  always_comb begin
    q0 = (c_div == DIV_1) ? c_xs : c_prod[2*XB-1:XB];
    case (c_div)
      DIV_3: begin qm = (q0 << 1) + q0; m = XB'(3); end
      DIV_9: begin qm = (q0 << 3) + q0; m = XB'(9); end
      default: begin qm = q0; m = XB'(1); end
    endcase
    rem = c_xs - qm;
    q = (rem >= m) ? q0 + XB'(1) : q0;
    qs = c_neg ? -q : q;
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      res.smoothed_height <= qs[SAMPLE_BITS-1:0];
      res.row_index       <= c_tag.row_index;
      res.col_index       <= c_tag.col_index;
      res.frame_last      <= c_tag.frame_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/height_map_box_smooth_core.sv =====
// top level of the streaming 3x3 box smoothing core for height maps
// result for a point passes stages s1, a, b, c and d after the request that completes
// its window, that is the request one row and one sample later; one request per cycle
// sustained while output is not stalled, set by one read and one write per line store
// per cycle and the window shift; synchronous reset clears counters and pipeline valids
// and sets a 256 x 256 map; line stores are not cleared and there is no clearing pass
`default_nettype none
module height_map_box_smooth_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hmbs_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [hmbs_pkg::DATA_BITS-1:0]    pwdata,
  output logic [hmbs_pkg::DATA_BITS-1:0]         prdata,
  output logic                                   pready,
  input  wire logic                              sample_valid,
  output logic                                   sample_ready,
  input  wire hmbs_pkg::sample_req_t             sample,
  output logic                                   smooth_valid,
  input  wire logic                              smooth_ready,
  output hmbs_pkg::smooth_req_t                  smooth
);
  import hmbs_pkg::*;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);

  logic [CFG_BITS-1:0] map_width, map_height;
  logic cfg_write;
  logic [WB-1:0] eff_w;
  logic [ROW_BITS-1:0] eff_h;

  logic [ROW_BITS-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [COL_BITS-1:0] in_col, in_col_next, out_col, out_col_next;

  logic accept, emit, col_end, last;
  sample_t in_v;
  point_tag_t tag;

  logic s1_valid, s1_ready, s1_go, s1_emit, s1_fwd;
  logic [COL_BITS-1:0] s1_col;
  sample_t s1_v, s1_fwd_data, rd_lower, rd_upper, top;
  point_tag_t s1_tag;

  sample_t line_lower [MAX_WIDTH];
  sample_t line_upper [MAX_WIDTH];

  window_t window, win_next;
  logic win_valid, win_ready;

  assign cfg_write = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_WIDTH_RESET;
      map_height <= MAP_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[2]))
        REG_MAP_WIDTH:  map_width  <= pwdata[CFG_BITS-1:0];
        REG_MAP_HEIGHT: map_height <= pwdata[CFG_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_MAP_WIDTH:  prdata = DATA_BITS'(map_width);
      REG_MAP_HEIGHT: prdata = DATA_BITS'(map_height);
    endcase
  end

  always_comb begin
    if (map_width == '0) begin
      eff_w = WB'(1);
    end else if (32'(map_width) > MAX_WIDTH) begin
      eff_w = WB'(MAX_WIDTH);
    end else begin
      eff_w = WB'(map_width);
    end
    if (map_height == '0) begin
      eff_h = ROW_BITS'(1);
    end else if (map_height > CFG_BITS'(HEIGHT_LIMIT)) begin
      eff_h = ROW_BITS'(HEIGHT_LIMIT);
    end else begin
      eff_h = ROW_BITS'(map_height);
    end
  end

  assign s1_go = s1_valid && (!s1_emit || win_ready);
  assign s1_ready = !s1_valid || s1_go;
  assign sample_ready = s1_ready;
  assign accept = sample_valid && s1_ready;

  always_comb begin
    col_end = (WB'(in_col) + WB'(1)) >= eff_w;
    in_v = (!sample.flush && in_row < eff_h) ? sample.height_sample : '0;
    emit = (in_row >= ROW_BITS'(2)) || (in_row == ROW_BITS'(1) && in_col != '0);
    tag.row_index  = INDEX_BITS'(out_row);
    tag.col_index  = INDEX_BITS'(out_col);
    tag.row_up     = out_row != '0;
    tag.row_dn     = (out_row + ROW_BITS'(1)) < eff_h;
    tag.col_left   = out_col != '0;
    tag.col_right  = (WB'(out_col) + WB'(1)) < eff_w;
    last = (out_row == eff_h - ROW_BITS'(1)) && (WB'(out_col) == eff_w - WB'(1));
    tag.frame_last = last;
  end

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (accept) begin
      if (col_end) begin
        in_col_next = '0;
        in_row_next = in_row + ROW_BITS'(1);
      end else begin
        in_col_next = in_col + COL_BITS'(1);
      end
      if (emit) begin
        if (!tag.col_right) begin
          out_col_next = '0;
          out_row_next = out_row + ROW_BITS'(1);
        end else begin
          out_col_next = out_col + COL_BITS'(1);
        end
      end
    end
    if ((accept && emit && last) || cfg_write) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) line_lower[in_col] <= in_v;
    if (s1_ready) rd_lower <= line_lower[in_col];
  end

  always_ff @(posedge clk) begin
    if (s1_go) line_upper[s1_col] <= rd_lower;
    if (s1_ready) rd_upper <= line_upper[in_col];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= sample_valid;
    end
  end

  // bypass when the outgoing request writes the column being read
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_col      <= in_col;
      s1_v        <= in_v;
      s1_emit     <= emit;
      s1_tag      <= tag;
      s1_fwd      <= s1_valid && (s1_col == in_col);
      s1_fwd_data <= rd_lower;
    end
  end

  assign top = s1_fwd ? s1_fwd_data : rd_upper;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_next[k] = window[k+3];
    end
    win_next[6] = top;
    win_next[7] = rd_lower;
    win_next[8] = s1_v;
  end

  always_ff @(posedge clk) begin
    if (s1_go) window <= win_next;
  end

  assign win_valid = s1_valid && s1_emit;

  hmbs_mean u_mean (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win_next),
    .tag       (s1_tag),
    .res_valid (smooth_valid),
    .res_ready (smooth_ready),
    .res       (smooth)
  );

endmodule
`default_nettype wire

// ===== rtl/hmbs_checker.sv =====
// port-level assertions for the height map box smooth core and their bind
`default_nettype none
`include "height_map_box_smooth_core_macros.svh"
module hmbs_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  sample_ready,
  input wire logic                  smooth_valid,
  input wire logic                  smooth_ready,
  input wire hmbs_pkg::smooth_req_t smooth
);

  `HMBS_ASSERT_NEXT(a_result_hold, clk, rst, smooth_valid && !smooth_ready, smooth_valid && $stable(smooth), "result changed while stalled")

  `HMBS_ASSERT_SAME(a_stall_source, clk, rst, !sample_ready, smooth_valid && !smooth_ready, "request stalled without a blocked result")

  `HMBS_ASSERT_SAME(a_raster_step, clk, rst, $past(smooth_valid && smooth_ready && !smooth.frame_last) && smooth_valid && smooth_ready, (smooth.row_index == $past(smooth.row_index) && smooth.col_index == $past(smooth.col_index) + 10'd1) || (smooth.row_index == $past(smooth.row_index) + 10'd1 && smooth.col_index == 10'd0), "results out of raster order")

  `HMBS_ASSERT_SAME(a_frame_restart, clk, rst, $past(smooth_valid && smooth_ready && smooth.frame_last) && smooth_valid && smooth_ready, smooth.row_index == 10'd0 && smooth.col_index == 10'd0, "new map does not start at origin")

endmodule

bind height_map_box_smooth_core hmbs_checker u_checker (.*);
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the height map 3x3 box smoothing core
`timescale 1ns / 100ps
module testbench;
  import hmbs_pkg::*;

  localparam int MAP_LIMIT = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic pready;
  logic sample_valid;
  logic sample_ready;
  sample_req_t sample;
  logic smooth_valid;
  logic smooth_ready;
  smooth_req_t smooth;

  bit tx_idle_on;
  bit rx_idle_on;
  int random_items;

  sample_t probe_vals[13] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                              16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh0000,
                              16'sh1234, 16'sh0000, 16'sh0000};
  logic probe_flush[13] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                            1'b1, 1'b0, 1'b1, 1'b1};

  function automatic int eff_size(logic [CFG_BITS-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAP_LIMIT) return MAP_LIMIT;
    return int'(raw);
  endfunction

  class box_mean_scoreboard;
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    int upper_row[MAP_LIMIT];
    int lower_row[MAP_LIMIT];
    int window[WIN_TAPS];
    int in_row;
    int in_col;
    int out_row;
    int out_col;
    smooth_req_t expected_points[$];
    int mismatches;
    int points_checked;

    function new();
      width_reg = MAP_WIDTH_RESET;
      height_reg = MAP_HEIGHT_RESET;
    endfunction

    function void set_register(reg_index_t idx, logic [CFG_BITS-1:0] value);
      case (idx)
        REG_MAP_WIDTH: width_reg = value;
        REG_MAP_HEIGHT: height_reg = value;
      endcase
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // shift one request through the line stores and window, predict the mean it releases
    function void note_sample(sample_req_t req);
      int w, h, c, v, top, mid, sum, n, mag, q, col, row;
      bit emit;
      smooth_req_t pt;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      c = (in_col >= w) ? 0 : in_col;
      v = (!req.flush && in_row < h) ? int'(req.height_sample) : 0;
      top = upper_row[c];
      mid = lower_row[c];
      upper_row[c] = mid;
      lower_row[c] = v;
      for (int k = 0; k < 6; k++) window[k] = window[k + 3];
      window[6] = top;
      window[7] = mid;
      window[8] = v;
      emit = (in_row >= 2) || (in_row == 1 && c >= 1);
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return;
      sum = 0;
      n = 0;
      for (int k = 0; k < 3; k++) begin
        col = out_col - 1 + k;
        if (col < 0 || col >= w) continue;
        for (int r = 0; r < 3; r++) begin
          row = out_row - 1 + r;
          if (row < 0 || row >= h) continue;
          sum += window[k * 3 + r];
          n++;
        end
      end
      mag = (sum < 0) ? -sum : sum;
      q = (2 * mag + n) / (2 * n);
      if (sum < 0) q = -q;
      pt.smoothed_height = sample_t'(q);
      pt.row_index = out_row[INDEX_BITS-1:0];
      pt.col_index = out_col[INDEX_BITS-1:0];
      pt.frame_last = (out_row == h - 1) && (out_col == w - 1);
      expected_points.push_back(pt);
      if (pt.frame_last) begin
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void report(string field, int want, int got);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endfunction

    function void check_point(smooth_req_t got);
      smooth_req_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: point expected none got %p", $time, got);
        return;
      end
      want = expected_points.pop_front();
      points_checked++;
      if (got.smoothed_height !== want.smoothed_height)
        report("smoothed_height", want.smoothed_height, got.smoothed_height);
      if (got.row_index !== want.row_index)
        report("row_index", want.row_index, got.row_index);
      if (got.col_index !== want.col_index)
        report("col_index", want.col_index, got.col_index);
      if (got.frame_last !== want.frame_last)
        report("frame_last", want.frame_last, got.frame_last);
    endfunction
  endclass

  box_mean_scoreboard sb = new();

  height_map_box_smooth_core #(.MAX_WIDTH(MAP_LIMIT)) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .smooth_valid(smooth_valid),
    .smooth_ready(smooth_ready),
    .smooth(smooth)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) sb.note_sample(sample);
      if (smooth_valid && smooth_ready) sb.check_point(smooth);
    end
  end

  function automatic int stall_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t random_height();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] random_extent();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'($urandom_range(9, 20));
      default: return 11'($urandom_range(2, 8));
    endcase
  endfunction

  // receiver side, with one long hold-off so the core backs up into its input
  initial begin
    int hold;
    int cyc;
    bit squeezed;
    hold = 0;
    cyc = 0;
    squeezed = 0;
    rx_idle_on = 1;
    smooth_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 300 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
      if (!squeezed && sb.points_checked >= 40 && sample_valid) begin
        squeezed = 1;
        hold = 400;
      end else if (hold == 0 && rx_idle_on && $urandom_range(0, 99) < 20) begin
        hold = stall_length();
      end
      if (hold > 0) begin
        hold--;
        smooth_ready <= 1'b0;
      end else begin
        smooth_ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input sample_req_t req);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? stall_length() : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= req;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic program_register(input reg_index_t idx, input logic [CFG_BITS-1:0] value);
    logic [DATA_BITS-1:0] word;
    word = $urandom;
    word[CFG_BITS-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(4 * int'(idx));
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_frames(input int w, input int h, input int frames);
    sample_req_t req;
    int span;
    int cut;
    span = w * h;
    for (int f = 0; f < frames; f++) begin
      cut = span + w + 1;
      if ($urandom_range(0, 99) < 8) cut = $urandom_range(1, span + w);
      for (int i = 0; i < cut; i++) begin
        req.height_sample = random_height();
        if (i < span) req.flush = ($urandom_range(0, 99) < 4);
        else req.flush = ($urandom_range(0, 99) >= 10);
        send_sample(req);
        random_items++;
      end
    end
  endtask

  initial begin
    logic [CFG_BITS-1:0] w_raw;
    logic [CFG_BITS-1:0] h_raw;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sample_valid <= 1'b0;
    sample <= '0;
    tx_idle_on = 1;
    random_items = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3 x 3 map: extremes, a flush inside the map, a sample after the map
    program_register(REG_MAP_WIDTH, 11'd3);
    program_register(REG_MAP_HEIGHT, 11'd3);
    for (int i = 0; i < 13; i++)
      send_sample('{height_sample: probe_vals[i], flush: probe_flush[i]});
    settle();
    // 2 x 2 map of the most negative height
    program_register(REG_MAP_WIDTH, 11'd2);
    program_register(REG_MAP_HEIGHT, 11'd2);
    for (int i = 0; i < 7; i++)
      send_sample('{height_sample: 16'sh8000, flush: i >= 4});

    while (random_items < 900) begin
      settle();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      w_raw = random_extent();
      h_raw = random_extent();
      program_register(REG_MAP_WIDTH, w_raw);
      program_register(REG_MAP_HEIGHT, h_raw);
      run_frames(eff_size(w_raw), eff_size(h_raw), $urandom_range(1, 4));
    end
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
